@@ hdl/tbbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_pkg
// Shared types and constants of the tile background blend store.
// ----------------------------------------------------------------------------
package tbbs_pkg;

  localparam int unsigned MaxCols = 64;
  localparam int unsigned MaxRows = 64;
  localparam int unsigned Depth   = MaxCols * MaxRows;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned DivW    = 16;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [7:0] ChanMax     = 8'hff;
  localparam logic [7:0] OverlayKnee = 8'd128;

  typedef enum logic [3:0] {
    ModeNone      = 4'd0,
    ModeSet       = 4'd1,
    ModeMultiply  = 4'd2,
    ModeLighten   = 4'd3,
    ModeDarken    = 4'd4,
    ModeScreen    = 4'd5,
    ModeDodge     = 4'd6,
    ModeColorBurn = 4'd7,
    ModeAdd       = 4'd8,
    ModeAddAlpha  = 4'd9,
    ModeBurn      = 4'd10,
    ModeOverlay   = 4'd11,
    ModeAlpha     = 4'd12,
    ModeDefault   = 4'd13
  } mode_e;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdRead  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CfgGridWidth    = 2'd0,
    CfgGridHeight   = 2'd1,
    CfgDefaultMode  = 2'd2,
    CfgDefaultAlpha = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       start;
    mode_e      mode;
    logic [7:0] alpha;
  } lane_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } lane_stat_t;

endpackage
`default_nettype wire

@@ hdl/tile_background_blend_store_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// flow: an input passes the read, start, wait and finish states before the result
//   is registered; dodge and color burn can wait on the bit-serial divider in each channel lane
// handshake: one item at a time, next input taken the cycle after the result is
//   registered; the finish state holds while the previous result is not taken
// reset: grid 64x64, default mode none; a pass then clears every tile of the store to
//   black, one tile per cycle, with in_ready_o low
// ----------------------------------------------------------------------------
// tile_background_blend_store_core
// Tile color store with per-channel blend lanes and a merging result stage.
// ----------------------------------------------------------------------------
module tile_background_blend_store_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [5:0] tile_x_i,
  input  logic [5:0] tile_y_i,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [3:0] blend_mode_i,
  input  logic [7:0] blend_alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic       tile_valid_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StStart = 5'b00100,
    StWait  = 5'b01000,
    StFin   = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [6:0]                   grid_w_q, grid_h_q;
  logic [3:0]                   def_mode_q;
  logic [7:0]                   def_alpha_q;
  logic                         clr_active_q;
  logic [tbbs_pkg::AddrW-1:0]   clr_addr_q;

  logic                         cmd_q;
  logic                         inside_q;
  logic [tbbs_pkg::AddrW-1:0]   addr_q;
  logic [7:0]                   src_q [3];
  tbbs_pkg::mode_e              mode_q;
  logic [7:0]                   alpha_q;
  logic [23:0]                  old_q;

  logic                         out_valid_q;
  logic [7:0]                   out_red_q, out_green_q, out_blue_q;
  logic                         tile_valid_q;

  logic [23:0]                  mem [tbbs_pkg::Depth];
  logic                         mem_we;
  logic [tbbs_pkg::AddrW-1:0]   mem_waddr;
  logic [23:0]                  mem_wdata;

  logic                         in_xfer;
  logic                         fin_go;
  logic                         all_done;
  logic                         inside_d;
  logic [3:0]                   mode_sel;
  logic [7:0]                   alpha_sel;
  tbbs_pkg::lane_ctrl_t         lane_ctrl;
  tbbs_pkg::lane_stat_t         lane_stat [3];
  logic [23:0]                  new_color;
  logic [23:0]                  res_color;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle) && !clr_active_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign fin_go      = !out_valid_q || out_ready_i;
  assign all_done    = lane_stat[0].done && lane_stat[1].done && lane_stat[2].done;

  always_comb begin
    inside_d = ({1'b0, tile_x_i} < grid_w_q) && ({1'b0, tile_y_i} < grid_h_q) &&
               (32'(tile_x_i) < tbbs_pkg::MaxCols) && (32'(tile_y_i) < tbbs_pkg::MaxRows);
    if (blend_mode_i == tbbs_pkg::ModeDefault) begin
      mode_sel  = def_mode_q;
      alpha_sel = def_alpha_q;
    end else begin
      mode_sel  = blend_mode_i;
      alpha_sel = blend_alpha_i;
    end
    // codes past alpha lerp keep the tile as it is
    if (mode_sel inside {[4'd13:4'd15]}) begin
      mode_sel = tbbs_pkg::ModeNone;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_xfer) state_d = StRead;
      StRead:  state_d = StStart;
      StStart: state_d = StWait;
      StWait:  if (all_done) state_d = StFin;
      StFin:   if (fin_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      grid_w_q     <= 7'd64;
      grid_h_q     <= 7'd64;
      def_mode_q   <= 4'd0;
      def_alpha_q  <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == tbbs_pkg::AddrW'(tbbs_pkg::Depth - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (tbbs_pkg::cfg_idx_e'(cfg_index_i))
          tbbs_pkg::CfgGridWidth:    grid_w_q    <= cfg_data_i[6:0];
          tbbs_pkg::CfgGridHeight:   grid_h_q    <= cfg_data_i[6:0];
          tbbs_pkg::CfgDefaultMode:  def_mode_q  <= cfg_data_i[3:0];
          tbbs_pkg::CfgDefaultAlpha: def_alpha_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StFin && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= cmd_i;
      inside_q <= inside_d;
      addr_q   <= tbbs_pkg::AddrW'(int'(tile_y_i) * tbbs_pkg::MaxCols + int'(tile_x_i));
      src_q[0] <= src_red_i;
      src_q[1] <= src_green_i;
      src_q[2] <= src_blue_i;
      mode_q   <= tbbs_pkg::mode_e'(mode_sel);
      alpha_q  <= alpha_sel;
    end
    if (state_q == StFin && fin_go) begin
      out_red_q    <= res_color[23:16];
      out_green_q  <= res_color[15:8];
      out_blue_q   <= res_color[7:0];
      tile_valid_q <= inside_q;
    end
  end

  // tile store
  assign mem_we    = clr_active_q ||
                     (state_q == StFin && fin_go && inside_q && cmd_q == tbbs_pkg::CmdWrite);
  assign mem_waddr = clr_active_q ? clr_addr_q : addr_q;
  assign mem_wdata = clr_active_q ? 24'd0 : new_color;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == StRead) begin
      old_q <= mem[addr_q];
    end
  end

  // one lane per channel, red first
  assign lane_ctrl.start = (state_q == StStart);
  assign lane_ctrl.mode  = mode_q;
  assign lane_ctrl.alpha = alpha_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tbbs_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .old_i  (old_q[8*(2-i) +: 8]),
      .new_i  (src_q[i]),
      .stat_o (lane_stat[i])
    );
  end

  // merge the lanes into the result
  assign new_color = {lane_stat[0].value, lane_stat[1].value, lane_stat[2].value};

  always_comb begin
    if (!inside_q) begin
      res_color = 24'd0;
    end else if (cmd_q == tbbs_pkg::CmdRead) begin
      res_color = old_q;
    end else begin
      res_color = new_color;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_red_q;
  assign out_green_o  = out_green_q;
  assign out_blue_o   = out_blue_q;
  assign tile_valid_o = tile_valid_q;

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> (state_q == StIdle))
    else $error("item in flight during store clear");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFin))
    else $error("result raised outside the finish step");

  a_write_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clr_active_q) |-> (inside_q && cmd_q == tbbs_pkg::CmdWrite))
    else $error("store written for a read or an outside tile");

  a_lanes_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait && all_done) |=> (state_q == StFin))
    else $error("lanes done but merge step missed");

endmodule
`default_nettype wire

@@ hdl/tbbs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_div
// Restoring divider, one quotient bit per cycle, 16-bit by 8-bit.
// ----------------------------------------------------------------------------
module tbbs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbbs_pkg::DivW-1:0]   dividend_i,
  input  logic [7:0]                  divisor_i,
  output logic                        done_o,
  output logic [tbbs_pkg::DivW-1:0]   quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tbbs_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [tbbs_pkg::DivW-1:0]      quo_q, quo_d;
  logic [7:0]                     dsr_q, dsr_d;
  logic [7:0]                     rem_q, rem_d;
  logic [8:0]                     trial;
  logic [8:0]                     diff;

  always_comb begin
    trial  = {rem_q, quo_q[tbbs_pkg::DivW-1]};
    diff   = trial - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so eight bits hold it
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[7:0];
        quo_d = {quo_q[tbbs_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[tbbs_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tbbs_pkg::DivCntW'(tbbs_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

@@ hdl/tbbs_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_lane
// Blend of one color channel: single multiplier with a divide-by-255 step,
// plus a private divider for dodge and color burn.
// ----------------------------------------------------------------------------
module tbbs_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbbs_pkg::lane_ctrl_t  ctrl_i,
  input  logic [7:0]            old_i,
  input  logic [7:0]            new_i,
  output tbbs_pkg::lane_stat_t  stat_o
);

  logic [7:0]                     inv_a, inv_b, diff_ab;
  logic [7:0]                     op_x, op_y;
  logic [15:0]                    prod;
  logic [16:0]                    scaled, plus1;
  logic [24:0]                    recip;
  logic [8:0]                     q;
  logic [7:0]                     q_sat;
  logic [8:0]                     sum_ab;
  logic [9:0]                     sum_aq;
  logic [7:0]                     fast;
  logic                           need_div;
  logic [tbbs_pkg::DivW-1:0]      div_dvd;
  logic [7:0]                     div_dsr;
  logic                           div_done;
  logic [tbbs_pkg::DivW-1:0]      div_quo;
  logic [7:0]                     div_res;
  logic                           done_q;
  logic [7:0]                     value_q;

  always_comb begin
    inv_a   = ~old_i;
    inv_b   = ~new_i;
    diff_ab = (new_i >= old_i) ? (new_i - old_i) : (old_i - new_i);
    op_x    = old_i;
    op_y    = new_i;
    case (ctrl_i.mode)
      tbbs_pkg::ModeScreen: begin
        op_x = inv_a;
        op_y = inv_b;
      end
      tbbs_pkg::ModeAddAlpha: begin
        op_x = ctrl_i.alpha;
        op_y = new_i;
      end
      tbbs_pkg::ModeOverlay: begin
        if (new_i > tbbs_pkg::OverlayKnee) begin
          op_x = inv_a;
          op_y = inv_b;
        end
      end
      tbbs_pkg::ModeAlpha: begin
        op_x = diff_ab;
        op_y = ctrl_i.alpha;
      end
      default: begin
        op_x = old_i;
        op_y = new_i;
      end
    endcase
    prod   = op_x * op_y;
    scaled = (ctrl_i.mode == tbbs_pkg::ModeOverlay) ? {prod, 1'b0} : {1'b0, prod};
    // x / 255 == ((x + 1) * 257) >> 16 for 16-bit x
    plus1  = scaled + 17'd1;
    recip  = {8'd0, plus1} + {plus1, 8'd0};
    q      = recip[24:16];
    q_sat  = q[8] ? tbbs_pkg::ChanMax : q[7:0];
    sum_ab = {1'b0, old_i} + {1'b0, new_i};
    sum_aq = {2'b00, old_i} + {1'b0, q};
  end

  always_comb begin
    case (ctrl_i.mode)
      tbbs_pkg::ModeSet:       fast = new_i;
      tbbs_pkg::ModeMultiply:  fast = q_sat;
      tbbs_pkg::ModeLighten:   fast = (old_i > new_i) ? old_i : new_i;
      tbbs_pkg::ModeDarken:    fast = (old_i < new_i) ? old_i : new_i;
      tbbs_pkg::ModeScreen:    fast = tbbs_pkg::ChanMax - q_sat;
      tbbs_pkg::ModeDodge:     fast = tbbs_pkg::ChanMax;
      tbbs_pkg::ModeColorBurn: fast = 8'd0;
      tbbs_pkg::ModeAdd:       fast = sum_ab[8] ? tbbs_pkg::ChanMax : sum_ab[7:0];
      tbbs_pkg::ModeAddAlpha:  fast = (sum_aq > 10'd255) ? tbbs_pkg::ChanMax : sum_aq[7:0];
      tbbs_pkg::ModeBurn:      fast = (sum_ab < 9'd255) ? 8'd0 : 8'(sum_ab - 9'd255);
      tbbs_pkg::ModeOverlay: begin
        fast = (new_i <= tbbs_pkg::OverlayKnee) ? q_sat : (tbbs_pkg::ChanMax - q_sat);
      end
      // truncation toward zero: the step never overshoots the distance
      tbbs_pkg::ModeAlpha:     fast = (new_i >= old_i) ? (old_i + q[7:0]) : (old_i - q[7:0]);
      default:                 fast = old_i;
    endcase
  end

  always_comb begin
    need_div = ((ctrl_i.mode == tbbs_pkg::ModeDodge) && (old_i != tbbs_pkg::ChanMax)) ||
               ((ctrl_i.mode == tbbs_pkg::ModeColorBurn) && (new_i != 8'd0));
    if (ctrl_i.mode == tbbs_pkg::ModeDodge) begin
      div_dvd = {new_i, 8'd0} - {8'd0, new_i};
      div_dsr = inv_a;
    end else begin
      div_dvd = {inv_a, 8'd0} - {8'd0, inv_a};
      div_dsr = new_i;
    end
    if (ctrl_i.mode == tbbs_pkg::ModeDodge) begin
      div_res = (|div_quo[tbbs_pkg::DivW-1:8]) ? tbbs_pkg::ChanMax : div_quo[7:0];
    end else begin
      div_res = (|div_quo[tbbs_pkg::DivW-1:8]) ? 8'd0 : (tbbs_pkg::ChanMax - div_quo[7:0]);
    end
  end

  tbbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.start && need_div),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      done_q <= !need_div;
    end else if (div_done) begin
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !need_div) begin
      value_q <= fast;
    end else if (div_done) begin
      value_q <= div_res;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.value = value_q;

endmodule
`default_nettype wire

@@ tb/tile_background_blend_store_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_blend_store_core_tb
// Drives blend-write and read transfers into the tile store, predicts every
// result with a local model of the color grid and checks each output transfer.
// ----------------------------------------------------------------------------
module tile_background_blend_store_core_tb;

  localparam int unsigned CycleLimit = 2000000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_i;
  logic [5:0] tile_x_i;
  logic [5:0] tile_y_i;
  logic [7:0] src_red_i;
  logic [7:0] src_green_i;
  logic [7:0] src_blue_i;
  logic [3:0] blend_mode_i;
  logic [7:0] blend_alpha_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic       tile_valid_o;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       tile_ok;
  } tile_result_t;

  logic [23:0]  color_grid [tbbs_pkg::Depth];
  logic [6:0]   cols_in_use;
  logic [6:0]   rows_in_use;
  logic [3:0]   fallback_mode;
  logic [7:0]   fallback_alpha;
  tile_result_t pending_colors[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  hold_cycles;

  tile_background_blend_store_core i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int blend_lane(logic [3:0] mode, int a, int b, int alpha);
    int r;
    case (mode)
      tbbs_pkg::ModeSet:       r = b;
      tbbs_pkg::ModeMultiply:  r = a * b / 255;
      tbbs_pkg::ModeLighten:   r = a > b ? a : b;
      tbbs_pkg::ModeDarken:    r = a < b ? a : b;
      tbbs_pkg::ModeScreen:    r = 255 - (255 - a) * (255 - b) / 255;
      tbbs_pkg::ModeDodge:     r = (a == 255) ? 255 : 255 * b / (255 - a);
      tbbs_pkg::ModeColorBurn: r = (b == 0) ? 0 : 255 - (255 * (255 - a)) / b;
      tbbs_pkg::ModeAdd:       r = a + b;
      tbbs_pkg::ModeAddAlpha:  r = a + alpha * b / 255;
      tbbs_pkg::ModeBurn:      r = a + b - 255;
      tbbs_pkg::ModeOverlay: begin
        r = (b <= 128) ? 2 * b * a / 255 : 255 - 2 * (255 - b) * (255 - a) / 255;
      end
      tbbs_pkg::ModeAlpha:     r = a + ((b - a) * alpha) / 255;
      default:                 r = a;
    endcase
    return r < 0 ? 0 : (r > 255 ? 255 : r);
  endfunction

  // updates the local grid and returns what the block must answer
  function automatic tile_result_t predict_tile(logic cmd, logic [5:0] x, logic [5:0] y,
                                                logic [23:0] src, logic [3:0] mode,
                                                logic [7:0] alpha);
    tile_result_t res;
    logic [23:0]  color;
    logic [3:0]   m;
    int           al;
    int           addr;
    res = '0;
    m = mode;
    al = alpha;
    if (x < cols_in_use && y < rows_in_use) begin
      addr = y * tbbs_pkg::MaxCols + x;
      color = color_grid[addr];
      if (cmd == tbbs_pkg::CmdWrite) begin
        if (m == tbbs_pkg::ModeDefault) begin
          m = fallback_mode;
          al = fallback_alpha;
        end
        for (int i = 0; i < 3; i++) begin
          color[8*i +: 8] = 8'(blend_lane(m, color_grid[addr][8*i +: 8], src[8*i +: 8], al));
        end
        color_grid[addr] = color;
      end
      res = {color, 1'b1};
    end
    return res;
  endfunction

  task automatic write_reg(tbbs_pkg::cfg_idx_e idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      tbbs_pkg::CfgGridWidth:   cols_in_use = data[6:0];
      tbbs_pkg::CfgGridHeight:  rows_in_use = data[6:0];
      tbbs_pkg::CfgDefaultMode: fallback_mode = data[3:0];
      default:                  fallback_alpha = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_tile(logic cmd, logic [5:0] x, logic [5:0] y, logic [23:0] src,
                           logic [3:0] mode, logic [7:0] alpha, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    // the previous transfer released valid at an earlier falling edge
    @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    cmd_i         <= cmd;
    tile_x_i      <= x;
    tile_y_i      <= y;
    src_red_i     <= src[23:16];
    src_green_i   <= src[15:8];
    src_blue_i    <= src[7:0];
    blend_mode_i  <= mode;
    blend_alpha_i <= alpha;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_colors.push_back(predict_tile(cmd, x, y, src, mode, alpha));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n, int tiles);
    for (int k = 0; k < n; k++) begin
      send_tile($urandom_range(0, 3) == 0, 6'($urandom_range(0, tiles)),
                6'($urandom_range(0, tiles)), 24'($urandom), 4'($urandom_range(0, 15)),
                8'($urandom), 1'b1);
    end
  endtask

  // ready process: ready toggles at random, long hold when requested
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      out_ready_i <= stall == 0;
      if (stall != 0) begin
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    tile_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        exp_res = pending_colors.pop_front();
        if (out_red_o !== exp_res.red) begin
          $error("out_red exp %0d got %0d", exp_res.red, out_red_o);
          error_count++;
        end
        if (out_green_o !== exp_res.green) begin
          $error("out_green exp %0d got %0d", exp_res.green, out_green_o);
          error_count++;
        end
        if (out_blue_o !== exp_res.blue) begin
          $error("out_blue exp %0d got %0d", exp_res.blue, out_blue_o);
          error_count++;
        end
        if (tile_valid_o !== exp_res.tile_ok) begin
          $error("tile_valid exp %0d got %0d", exp_res.tile_ok, tile_valid_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_modes();
    send_tile(tbbs_pkg::CmdRead, 0, 0, 0, tbbs_pkg::ModeNone, 0, 0);
    send_tile(tbbs_pkg::CmdWrite, 0, 0, 24'hff8000, tbbs_pkg::ModeSet, 0, 0);
    for (int m = 0; m < 16; m++) begin
      send_tile(tbbs_pkg::CmdWrite, 0, 0, {8'(m * 17), 8'hff, 8'h00}, 4'(m), 8'(m * 20),
                1'b1);
      send_tile(tbbs_pkg::CmdWrite, 1, 0, {8'h81, 8'h80, 8'h00}, tbbs_pkg::ModeSet, 0, 1'b1);
    end
    send_tile(tbbs_pkg::CmdWrite, 63, 63, 24'hffffff, tbbs_pkg::ModeAlpha, 8'hff, 0);
    send_tile(tbbs_pkg::CmdRead, 63, 63, 0, tbbs_pkg::ModeNone, 0, 0);
    send_tile(tbbs_pkg::CmdWrite, 2, 2, 24'h7f0080, tbbs_pkg::ModeDodge, 0, 0);
    send_tile(tbbs_pkg::CmdWrite, 2, 2, 24'h000180, tbbs_pkg::ModeColorBurn, 0, 0);
    drain_results();
  endtask

  task automatic test_config_and_grid();
    write_reg(tbbs_pkg::CfgGridWidth, 8'd1);
    write_reg(tbbs_pkg::CfgGridHeight, 8'd1);
    write_reg(tbbs_pkg::CfgDefaultMode, 8'(tbbs_pkg::ModeAlpha));
    write_reg(tbbs_pkg::CfgDefaultAlpha, 8'hff);
    send_tile(tbbs_pkg::CmdWrite, 0, 0, 24'h123456, tbbs_pkg::ModeDefault, 0, 0);
    send_tile(tbbs_pkg::CmdWrite, 1, 0, 24'h123456, tbbs_pkg::ModeSet, 0, 0);
    send_tile(tbbs_pkg::CmdRead, 0, 1, 0, tbbs_pkg::ModeNone, 0, 0);
    send_random(40, 2);
    drain_results();
    write_reg(tbbs_pkg::CfgGridWidth, 8'd0);
    write_reg(tbbs_pkg::CfgDefaultMode, 8'd15);
    send_random(20, 3);
    drain_results();
    write_reg(tbbs_pkg::CfgGridWidth, 8'd127);
    write_reg(tbbs_pkg::CfgGridHeight, 8'd64);
    write_reg(tbbs_pkg::CfgDefaultMode, 8'(tbbs_pkg::ModeAddAlpha));
    write_reg(tbbs_pkg::CfgDefaultAlpha, 8'd0);
    send_random(60, 63);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(tbbs_pkg::CfgGridWidth, 8'($urandom_range(1, 64)));
      write_reg(tbbs_pkg::CfgGridHeight, 8'($urandom_range(1, 64)));
      write_reg(tbbs_pkg::CfgDefaultMode, 8'($urandom_range(0, 15)));
      write_reg(tbbs_pkg::CfgDefaultAlpha, 8'($urandom));
      // odd phases use few tiles so writes pile onto the same colors
      send_random(120, phase[0] ? 7 : 63);
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int k = 0; k < 30; k++) begin
      send_tile(tbbs_pkg::CmdWrite, 3, 3, 24'($urandom), 4'($urandom_range(0, 13)),
                8'($urandom), 1'b0);
    end
    drain_results();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    for (int i = 0; i < tbbs_pkg::Depth; i++) color_grid[i] = '0;
    cols_in_use = 7'd64;
    rows_in_use = 7'd64;
    fallback_mode = tbbs_pkg::ModeNone;
    fallback_alpha = 8'd0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tbbs_pkg::CfgGridWidth;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = tbbs_pkg::CmdWrite;
    tile_x_i = '0;
    tile_y_i = '0;
    src_red_i = '0;
    src_green_i = '0;
    src_blue_i = '0;
    blend_mode_i = tbbs_pkg::ModeNone;
    blend_alpha_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_modes();
    test_config_and_grid();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
